>>> rtl/ttm_pkg.sv
// Package for the touch to mouse tap-click block: widths, register codes,
// result word type and the motion and drift helper functions.
// Depends on nothing; every other file uses it.
package ttm_pkg;

   localparam int COORD_BITS = 10;
   localparam int MOVE_BITS  = 8;
   localparam int GAIN_BITS  = 4;
   localparam int THR_BITS   = 8;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 8;
   localparam int PROD_BITS  = COORD_BITS + GAIN_BITS + 2;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

   localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(3);
   localparam logic [THR_BITS-1:0]  THR_RESET  = THR_BITS'(3);
   localparam logic signed [PROD_BITS-1:0] PROD_MAX = PROD_BITS'(127);
   localparam logic signed [PROD_BITS-1:0] PROD_MIN = -PROD_BITS'(128);
   localparam logic signed [MOVE_BITS-1:0] MOVE_MAX = MOVE_BITS'(127);
   localparam logic signed [MOVE_BITS-1:0] MOVE_MIN = MOVE_BITS'(128);
   localparam logic BUTTON_LEFT = 1'b1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MOTION_GAIN     = 2'd0,
      CSR_CLICK_THRESHOLD = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic                        left_button;
      logic signed [MOVE_BITS-1:0] move_x;
      logic signed [MOVE_BITS-1:0] move_y;
      logic                        last_report;
   } rsp_word_type;

   typedef struct packed {
      logic valid;
      logic pair;
   } push_type;

   typedef struct packed {
      logic room_one;
      logic room_two;
   } room_type;

   function automatic logic signed [MOVE_BITS-1:0] scaled_move(
      input logic [COORD_BITS-1:0] now,
      input logic [COORD_BITS-1:0] prior,
      input logic [GAIN_BITS-1:0]  gain);
      logic signed [COORD_BITS:0]   d;
      logic signed [PROD_BITS-1:0]  p;
      logic signed [MOVE_BITS-1:0]  r;
      d = $signed({1'b0, now}) - $signed({1'b0, prior});
      p = PROD_BITS'(d) * $signed({{(PROD_BITS-GAIN_BITS){1'b0}}, gain});
      if (p > PROD_MAX) begin
         r = MOVE_MAX;
      end else if (p < PROD_MIN) begin
         r = MOVE_MIN;
      end else begin
         r = p[MOVE_BITS-1:0];
      end
      return r;
   endfunction

   function automatic logic drift_exceeds(
      input logic [COORD_BITS-1:0] now,
      input logic [COORD_BITS-1:0] origin,
      input logic [THR_BITS-1:0]   thr);
      logic [COORD_BITS-1:0] gap;
      gap = (now >= origin) ? now - origin : origin - now;
      return gap > COORD_BITS'(thr);
   endfunction

endpackage

>>> rtl/ttm_ifs.sv
// Valid/ready channel interfaces for sample, report and register-write words.
// Depends on ttm_pkg.
interface ttm_req_if;
   logic                            valid;
   logic                            ready;
   logic                            touch_detected;
   logic [ttm_pkg::COORD_BITS-1:0]  touch_x;
   logic [ttm_pkg::COORD_BITS-1:0]  touch_y;
   modport source (output valid, output touch_detected, output touch_x, output touch_y,
                   input ready);
   modport sink (input valid, input touch_detected, input touch_x, input touch_y,
                 output ready);
endinterface

interface ttm_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   left_button;
   logic signed [ttm_pkg::MOVE_BITS-1:0]   move_x;
   logic signed [ttm_pkg::MOVE_BITS-1:0]   move_y;
   logic                                   last_report;
   modport source (output valid, output left_button, output move_x, output move_y,
                   output last_report, input ready);
   modport sink (input valid, input left_button, input move_x, input move_y,
                 input last_report, output ready);
endinterface

interface ttm_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ttm_pkg::CSR_IDX_BITS-1:0]   index;
   logic [ttm_pkg::CSR_DATA_BITS-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/ttm_core.sv
// Sample register, touch tracking state and report generation.
// Depends on ttm_pkg.
module ttm_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic                             in_touch,
   input  logic [ttm_pkg::COORD_BITS-1:0]   in_x,
   input  logic [ttm_pkg::COORD_BITS-1:0]   in_y,
   input  logic [ttm_pkg::GAIN_BITS-1:0]    gain,
   input  logic [ttm_pkg::THR_BITS-1:0]     threshold,
   input  ttm_pkg::room_type                room,
   output ttm_pkg::push_type                push,
   output ttm_pkg::rsp_word_type            word0,
   output ttm_pkg::rsp_word_type            word1
);
   import ttm_pkg::*;

   logic                  stage_valid_ff, stage_valid_in;
   logic                  stage_touch_ff;
   logic [COORD_BITS-1:0] stage_x_ff, stage_y_ff;
   logic                  active_ff, active_in;
   logic                  armed_ff, armed_in;
   logic [COORD_BITS-1:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [COORD_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                  want_one, want_two, consume, accept;

   assign want_one = stage_touch_ff && active_ff;
   assign want_two = !stage_touch_ff && armed_ff;
   assign consume  = stage_valid_ff && (want_one ? room.room_one :
                                        want_two ? room.room_two : 1'b1);
   assign in_ready = !stage_valid_ff || consume;
   assign accept   = in_valid && in_ready;
   assign stage_valid_in = accept || (stage_valid_ff && !consume);

   always_comb begin
      push.valid = consume && (want_one || want_two);
      push.pair  = want_two;
      word0.left_button = 1'b0;
      word0.move_x      = scaled_move(stage_x_ff, prev_x_ff, gain);
      word0.move_y      = scaled_move(stage_y_ff, prev_y_ff, gain);
      word0.last_report = 1'b1;
      word1.left_button = 1'b0;
      word1.move_x      = '0;
      word1.move_y      = '0;
      word1.last_report = 1'b1;
      if (want_two) begin
         word0.left_button = BUTTON_LEFT;
         word0.move_x      = '0;
         word0.move_y      = '0;
         word0.last_report = 1'b0;
      end
   end

   always_comb begin
      active_in  = active_ff;
      armed_in   = armed_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      if (consume) begin
         if (stage_touch_ff) begin
            prev_x_in = stage_x_ff;
            prev_y_in = stage_y_ff;
            if (!active_ff) begin
               active_in  = 1'b1;
               armed_in   = 1'b1;
               start_x_in = stage_x_ff;
               start_y_in = stage_y_ff;
            end else if (drift_exceeds(stage_x_ff, start_x_ff, threshold) ||
                         drift_exceeds(stage_y_ff, start_y_ff, threshold)) begin
               armed_in = 1'b0;
            end
         end else begin
            active_in = 1'b0;
            armed_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         active_ff      <= 1'b0;
         armed_ff       <= 1'b0;
         start_x_ff     <= '0;
         start_y_ff     <= '0;
         prev_x_ff      <= '0;
         prev_y_ff      <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         active_ff      <= active_in;
         armed_ff       <= armed_in;
         start_x_ff     <= start_x_in;
         start_y_ff     <= start_y_in;
         prev_x_ff      <= prev_x_in;
         prev_y_ff      <= prev_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_touch_ff <= in_touch;
         stage_x_ff     <= in_x;
         stage_y_ff     <= in_y;
      end
   end

endmodule

>>> rtl/ttm_out_fifo.sv
// Report queue: takes one or two words a cycle, hands out one.
// Depends on ttm_pkg.
module ttm_out_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  ttm_pkg::push_type      push,
   input  ttm_pkg::rsp_word_type  word0,
   input  ttm_pkg::rsp_word_type  word1,
   output ttm_pkg::room_type      room,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ttm_pkg::rsp_word_type  out_word
);
   import ttm_pkg::*;

   rsp_word_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_BITS:0]   count_ff, count_in, count_left;
   logic                     pop;

   assign out_valid  = count_ff != '0;
   assign out_word   = mem_ff[rd_ptr_ff];
   assign pop        = out_valid && out_ready;
   assign count_left = count_ff - (FIFO_PTR_BITS+1)'(pop);
   assign room.room_one = count_left <= (FIFO_PTR_BITS+1)'(FIFO_DEPTH - 1);
   assign room.room_two = count_left <= (FIFO_PTR_BITS+1)'(FIFO_DEPTH - 2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_left;
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_BITS'(pop);
      if (push.valid) begin
         wr_ptr_in = wr_ptr_ff + (push.pair ? FIFO_PTR_BITS'(2) : FIFO_PTR_BITS'(1));
         count_in  = count_left + (push.pair ? (FIFO_PTR_BITS+1)'(2)
                                             : (FIFO_PTR_BITS+1)'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= word0;
         if (push.pair) begin
            mem_ff[wr_ptr_ff + FIFO_PTR_BITS'(1)] <= word1;
         end
      end
   end

endmodule

>>> rtl/touch_to_mouse_tap_click.sv
// Top level of the touch to mouse tap-click block: register port, core, report queue.
// Depends on ttm_pkg, ttm_ifs, ttm_core and ttm_out_fifo.
//
// Turns touch samples into relative-mouse report words. One sample is taken per clock
// cycle unless the report queue is short of room; each passes a one-deep sample register
// and leaves its reports in a four-word queue. A motion sample gives one word, a tap
// release gives a press word and a release word, which the single-word output port
// hands out one after the other. Register writes are taken every cycle and should be
// made while no samples are in flight.
module touch_to_mouse_tap_click (
   input  logic       clock,
   input  logic       reset,
   ttm_req_if.sink    req_word,
   ttm_rsp_if.source  rsp_word,
   ttm_csr_if.sink    csr_word
);
   import ttm_pkg::*;

   logic [GAIN_BITS-1:0] gain_ff;
   logic [THR_BITS-1:0]  threshold_ff;
   push_type             push;
   room_type             room;
   rsp_word_type         word0, word1, out_word;

   assign csr_word.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_RESET;
         threshold_ff <= THR_RESET;
      end else if (csr_word.valid) begin
         case (csr_word.index)
            CSR_MOTION_GAIN:     gain_ff      <= csr_word.data[GAIN_BITS-1:0];
            CSR_CLICK_THRESHOLD: threshold_ff <= csr_word.data[THR_BITS-1:0];
            default: ;
         endcase
      end
   end

   ttm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_word.valid),
      .in_ready  (req_word.ready),
      .in_touch  (req_word.touch_detected),
      .in_x      (req_word.touch_x),
      .in_y      (req_word.touch_y),
      .gain      (gain_ff),
      .threshold (threshold_ff),
      .room      (room),
      .push      (push),
      .word0     (word0),
      .word1     (word1)
   );

   ttm_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .word0     (word0),
      .word1     (word1),
      .room      (room),
      .out_valid (rsp_word.valid),
      .out_ready (rsp_word.ready),
      .out_word  (out_word)
   );

   assign rsp_word.left_button = out_word.left_button;
   assign rsp_word.move_x      = out_word.move_x;
   assign rsp_word.move_y      = out_word.move_y;
   assign rsp_word.last_report = out_word.last_report;

   a_pair_room: assert property (@(posedge clock) disable iff (reset)
      push.valid && push.pair |-> room.room_two)
      else $error("pair pushed without room for two words");

   a_one_room: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> room.room_one)
      else $error("word pushed into a full queue");

   a_press_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_word.valid && rsp_word.left_button |->
         !rsp_word.last_report && rsp_word.move_x == '0 && rsp_word.move_y == '0)
      else $error("press word carries motion or end mark");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_word.valid)
      else $error("report offered right after reset");

endmodule

>>> tb/ttm_report_checker.sv
// Report checker for the touch to mouse tap-click block: watches the sample,
// report and register channels, predicts the report words and compares them.
// Depends on ttm_pkg and ttm_ifs.
module ttm_report_checker (
   input  logic clock,
   input  logic reset,
   ttm_req_if   req_mon,
   ttm_rsp_if   rsp_mon,
   ttm_csr_if   csr_mon,
   output int   mismatches,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import ttm_pkg::*;

   localparam logic [GAIN_BITS-1:0] GAIN_AT_RESET      = 4'd3;
   localparam logic [THR_BITS-1:0]  THRESHOLD_AT_RESET = 8'd3;
   localparam int                   SHOWN_LIMIT        = 40;

   logic [GAIN_BITS-1:0]  gain;
   logic [THR_BITS-1:0]   threshold;
   bit                    touching;
   bit                    tap_armed;
   logic [COORD_BITS-1:0] origin_x, origin_y;
   logic [COORD_BITS-1:0] last_x, last_y;
   rsp_word_type          awaited_reports[$];
   rsp_word_type          oldest;
   int                    shown = 0;

   function automatic logic signed [MOVE_BITS-1:0] scale_delta(
      input logic [COORD_BITS-1:0] now,
      input logic [COORD_BITS-1:0] was,
      input logic [GAIN_BITS-1:0]  g);
      int p;
      p = (int'(now) - int'(was)) * int'(g);
      if (p > 127) begin
         p = 127;
      end else if (p < -128) begin
         p = -128;
      end
      return MOVE_BITS'(p);
   endfunction

   function automatic bit drifted(
      input logic [COORD_BITS-1:0] now,
      input logic [COORD_BITS-1:0] origin,
      input logic [THR_BITS-1:0]   limit);
      int d;
      d = int'(now) - int'(origin);
      if (d < 0) begin
         d = -d;
      end
      return d > int'(limit);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (shown < SHOWN_LIMIT) begin
         $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
      end
      shown++;
   endtask

   task automatic predict_reports(
      input bit                    touched,
      input logic [COORD_BITS-1:0] x,
      input logic [COORD_BITS-1:0] y);
      rsp_word_type w;
      if (touched && !touching) begin
         touching  = 1'b1;
         tap_armed = 1'b1;
         origin_x  = x;
         origin_y  = y;
         last_x    = x;
         last_y    = y;
      end else if (touched) begin
         w.left_button = !BUTTON_LEFT;
         w.move_x      = scale_delta(x, last_x, gain);
         w.move_y      = scale_delta(y, last_y, gain);
         w.last_report = 1'b1;
         awaited_reports.push_back(w);
         last_x = x;
         last_y = y;
         if (drifted(x, origin_x, threshold) || drifted(y, origin_y, threshold)) begin
            tap_armed = 1'b0;
         end
      end else begin
         touching = 1'b0;
         if (tap_armed) begin
            tap_armed     = 1'b0;
            w.left_button = BUTTON_LEFT;
            w.move_x      = '0;
            w.move_y      = '0;
            w.last_report = 1'b0;
            awaited_reports.push_back(w);
            w.left_button = !BUTTON_LEFT;
            w.last_report = 1'b1;
            awaited_reports.push_back(w);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gain      = GAIN_AT_RESET;
         threshold = THRESHOLD_AT_RESET;
         touching  = 1'b0;
         tap_armed = 1'b0;
         origin_x  = '0;
         origin_y  = '0;
         last_x    = '0;
         last_y    = '0;
         awaited_reports.delete();
         pending <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_MOTION_GAIN: begin
                  gain = csr_mon.data[GAIN_BITS-1:0];
               end
               CSR_CLICK_THRESHOLD: begin
                  threshold = csr_mon.data[THR_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_reports.size() == 0) begin
               report_mismatch("report word with none awaited",
                               int'({rsp_mon.left_button, rsp_mon.move_x,
                                     rsp_mon.move_y, rsp_mon.last_report}), 0);
            end else begin
               oldest = awaited_reports.pop_front();
               if (rsp_mon.left_button !== oldest.left_button) begin
                  report_mismatch("left_button", int'(rsp_mon.left_button),
                                  int'(oldest.left_button));
               end
               if (rsp_mon.move_x !== oldest.move_x) begin
                  report_mismatch("move_x", int'(rsp_mon.move_x), int'(oldest.move_x));
               end
               if (rsp_mon.move_y !== oldest.move_y) begin
                  report_mismatch("move_y", int'(rsp_mon.move_y), int'(oldest.move_y));
               end
               if (rsp_mon.last_report !== oldest.last_report) begin
                  report_mismatch("last_report", int'(rsp_mon.last_report),
                                  int'(oldest.last_report));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_reports(req_mon.touch_detected, req_mon.touch_x, req_mon.touch_y);
         end
         pending <= awaited_reports.size();
      end
   end

endmodule

>>> tb/tb_touch_to_mouse_tap_click.sv
// Testbench top for the touch to mouse tap-click block: clock, reset, sample and
// register-write stimulus, report-side back-pressure and the final verdict.
// Depends on ttm_pkg, ttm_ifs, touch_to_mouse_tap_click and ttm_report_checker.
module tb_touch_to_mouse_tap_click;
   timeunit 1ns;
   timeprecision 1ps;
   import ttm_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE      = 2'd3;
   localparam int                      ITEMS_PER_STEP = 135;
   localparam int                      HOLD_CYCLES    = 120;

   logic clock;
   logic reset;
   int   mismatches;
   int   pending;
   int   tx_idle_pct;
   int   rx_idle_pct;
   int   samples_sent = 0;
   bit   hold_trigger = 1'b0;
   bit   hold_seen    = 1'b0;
   int   hold_left    = 0;
   logic [THR_BITS-1:0] cur_threshold = 8'd3;

   ttm_req_if req_bus ();
   ttm_rsp_if rsp_bus ();
   ttm_csr_if csr_bus ();

   touch_to_mouse_tap_click dut (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_bus),
      .rsp_word (rsp_bus),
      .csr_word (csr_bus)
   );

   ttm_report_checker report_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_mon    (csr_bus),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always #5ns clock = ~clock;

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (hold_trigger != hold_seen) begin
         hold_seen = hold_trigger;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic send_sample(
      input bit                    touched,
      input logic [COORD_BITS-1:0] x,
      input logic [COORD_BITS-1:0] y);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_bus.valid          <= 1'b0;
         req_bus.touch_detected <= 1'($urandom_range(1));
         req_bus.touch_x        <= COORD_BITS'($urandom_range(1023));
         req_bus.touch_y        <= COORD_BITS'($urandom_range(1023));
         @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.touch_detected <= touched;
      req_bus.touch_x        <= x;
      req_bus.touch_y        <= y;
      do @(posedge clock); while (!req_bus.ready);
      samples_sent++;
   endtask

   task automatic write_register(
      input logic [CSR_IDX_BITS-1:0]  reg_index,
      input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= reg_index;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      if (reg_index == CSR_CLICK_THRESHOLD) begin
         cur_threshold = value;
      end
   endtask

   // hold the sample channel until every report is back and the pipe is empty
   task automatic drain_reports();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [COORD_BITS-1:0] drift_from(
      input logic [COORD_BITS-1:0] origin,
      input int                    span);
      int v;
      if ($urandom_range(9) == 0) begin
         return COORD_BITS'($urandom_range(1023));
      end
      v = int'(origin) + int'($urandom_range(2 * span)) - span;
      if (v < 0) begin
         v = 0;
      end else if (v > 1023) begin
         v = 1023;
      end
      return COORD_BITS'(v);
   endfunction

   task automatic play_gesture();
      int pick;
      int moves;
      int span;
      logic [COORD_BITS-1:0] x0, y0;
      pick = $urandom_range(99);
      if (pick < 10) begin
         send_sample(1'($urandom_range(1)), COORD_BITS'($urandom_range(1023)),
                     COORD_BITS'($urandom_range(1023)));
      end else begin
         x0    = COORD_BITS'($urandom_range(1023));
         y0    = COORD_BITS'($urandom_range(1023));
         span  = int'(cur_threshold) + 1;
         moves = $urandom_range(6);
         send_sample(1'b1, x0, y0);
         repeat (moves) send_sample(1'b1, drift_from(x0, span), drift_from(y0, span));
         // leave some touches open so the next start arrives as motion
         if (pick >= 17) begin
            send_sample(1'b0, COORD_BITS'($urandom_range(1023)),
                        COORD_BITS'($urandom_range(1023)));
         end
      end
   endtask

   task automatic apply_setting(input int step);
      logic [GAIN_BITS-1:0] g;
      logic [THR_BITS-1:0]  thr;
      case (step)
         0: begin
            g   = 4'd1;
            thr = 8'd0;
         end
         1: begin
            g   = 4'd15;
            thr = 8'd255;
         end
         2: begin
            g   = GAIN_BITS'($urandom_range(15, 1));
            thr = THR_BITS'($urandom_range(15));
         end
         default: begin
            g   = GAIN_BITS'($urandom_range(15, 1));
            thr = THR_BITS'($urandom_range(255));
         end
      endcase
      write_register(CSR_MOTION_GAIN, {4'($urandom_range(15)), g});
      write_register(CSR_CLICK_THRESHOLD, thr);
   endtask

   initial begin
      int  target;
      bit  paused;
      clock                  = 1'b0;
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.touch_detected = 1'b0;
      req_bus.touch_x        = '0;
      req_bus.touch_y        = '0;
      rsp_bus.ready          = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.index          = '0;
      csr_bus.data           = '0;
      tx_idle_pct            = 37;
      rx_idle_pct            = 83;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset gain and threshold: saturation both ways, taps, drift past threshold
      send_sample(1'b1, 10'd0, 10'd0);
      send_sample(1'b1, 10'd1023, 10'd1023);
      send_sample(1'b1, 10'd0, 10'd0);
      send_sample(1'b0, 10'd1023, 10'd0);
      send_sample(1'b0, 10'd0, 10'd1023);
      send_sample(1'b1, 10'd500, 10'd500);
      send_sample(1'b1, 10'd503, 10'd497);
      send_sample(1'b0, 10'd0, 10'd0);
      send_sample(1'b1, 10'd512, 10'd512);
      send_sample(1'b0, 10'd512, 10'd512);
      send_sample(1'b1, 10'd100, 10'd200);
      send_sample(1'b1, 10'd104, 10'd200);
      send_sample(1'b0, 10'd0, 10'd0);
      drain_reports();

      // zero gain and zero threshold, plus a write to an unused index
      write_register(CSR_MOTION_GAIN, 8'hA0);
      write_register(CSR_CLICK_THRESHOLD, 8'h00);
      write_register(CSR_SPARE, 8'h5F);
      send_sample(1'b1, 10'd10, 10'd10);
      send_sample(1'b1, 10'd10, 10'd10);
      send_sample(1'b1, 10'd11, 10'd9);
      send_sample(1'b0, 10'd0, 10'd0);
      send_sample(1'b1, 10'd7, 10'd7);
      send_sample(1'b0, 10'd7, 10'd7);
      drain_reports();

      // unit gain and widest threshold
      write_register(CSR_MOTION_GAIN, 8'h51);
      write_register(CSR_CLICK_THRESHOLD, 8'hFF);
      send_sample(1'b1, 10'd0, 10'd0);
      send_sample(1'b1, 10'd255, 10'd1);
      send_sample(1'b1, 10'd254, 10'd0);
      send_sample(1'b0, 10'd0, 10'd0);
      send_sample(1'b1, 10'd0, 10'd1023);
      send_sample(1'b1, 10'd1023, 10'd0);
      send_sample(1'b0, 10'd0, 10'd0);

      for (int regime = 0; regime < 3; regime++) begin
         case (regime)
            0: begin
               tx_idle_pct = 37;
               rx_idle_pct = 83;
            end
            1: begin
               tx_idle_pct = 83;
               rx_idle_pct = 37;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         for (int step = 0; step < 4; step++) begin
            drain_reports();
            apply_setting(step);
            target = samples_sent + ITEMS_PER_STEP;
            paused = 1'b0;
            if (step == 1) begin
               hold_trigger = !hold_trigger;
            end
            while (samples_sent < target) begin
               play_gesture();
               if (step == 2 && !paused && samples_sent >= target - ITEMS_PER_STEP / 2) begin
                  drain_reports();
                  paused = 1'b1;
               end
            end
         end
      end

      drain_reports();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_touch_to_mouse_tap_click OK");
      end else begin
         $display("tb_touch_to_mouse_tap_click NOT OK");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_touch_to_mouse_tap_click NOT OK");
      $finish;
   end

endmodule

>>> filelist.f
rtl/ttm_pkg.sv
rtl/ttm_ifs.sv
rtl/ttm_core.sv
rtl/ttm_out_fifo.sv
rtl/touch_to_mouse_tap_click.sv
tb/ttm_report_checker.sv
tb/tb_touch_to_mouse_tap_click.sv
